/* hw/rtl/cbe_pkg.sv */
package cbe_pkg;

    // newton iteration limit
    localparam int NewtonSteps = 6;
    localparam int IterW       = $clog2(NewtonSteps + 1);

    // unsigned q30 values: 1.0 = 2^30, held in 31 bits
    localparam int         QW    = 31;
    localparam logic [30:0] QONE = 31'h4000_0000;

    // flat derivative and tiny step threshold, 1e-6 in q30
    localparam int TinyQ30 = 1074;

    // divider widths: magnitudes of numerator and denominator, quotient bits
    localparam int DivW    = 34;
    localparam int QuoBits = 31;

    // accumulator for the x, d and y sums
    localparam int AccW = 50;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] ctrl_a_x;
        logic signed [15:0] ctrl_a_y;
        logic signed [15:0] ctrl_b_x;
        logic signed [15:0] ctrl_b_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] progress;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] eased_y;
        logic               hold_step;
    } t_out_item;

endpackage

/* hw/rtl/cbe_div.sv */
module cbe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cbe_pkg::DivW-1:0]    i_num,
    input  logic [cbe_pkg::DivW-1:0]    i_den,
    output logic                        o_done,
    output logic [cbe_pkg::QuoBits-1:0] o_quo
);
    import cbe_pkg::*;

    // restoring divider, one quotient bit a cycle: quo = (num * 2^30) / den
    // with num < 2 * den, so the quotient fits in QuoBits bits
    localparam int CntW = $clog2(QuoBits);

    logic [DivW:0]      r_rem, n_rem;
    logic [DivW-1:0]    r_den, n_den;
    logic [QuoBits-1:0] r_quo, n_quo;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_first, n_first;
    logic               r_done, n_done;
    logic [DivW:0]      trial;
    logic               ge;

    always_comb begin
        trial   = r_first ? r_rem : {r_rem[DivW-1:0], 1'b0};
        ge      = trial >= {1'b0, r_den};
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_first = r_first;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem   = {1'b0, i_num};
            n_den   = i_den;
            n_cnt   = '0;
            n_busy  = 1'b1;
            n_first = 1'b1;
        end else if (r_busy) begin
            n_rem   = ge ? trial - {1'b0, r_den} : trial;
            n_quo   = {r_quo[QuoBits-2:0], ge};
            n_first = 1'b0;
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == CntW'(QuoBits - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/cubic_bezier_ease_eval.sv */
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_stall   | i_in  (t_in_item)
// output  | out       | o_out_valid / i_out_stall | o_out (t_out_item)
//
// one item is in flight at a time; o_in_stall is low only while idle
// a hold step (span not positive) goes from idle through ST_FIN to the output register
// otherwise three normalizing divisions (setup plus the 31-bit bit-serial divide and
// its done strobe), then up to six newton steps on the one shared 32x32 multiplier
// and the divider, then the y sum; a clamp or an early exit skips some of this work
// the output register holds a finished result while i_out_stall is high
// i_rst_n is synchronous, active low, and clears the sequencer and valids
module cubic_bezier_ease_eval (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cbe_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cbe_pkg::t_out_item o_out
);
    import cbe_pkg::*;

    typedef enum logic [23:0] {
        ST_IDLE = 24'h000001,
        ST_NSET = 24'h000002,
        ST_NDIV = 24'h000004,
        ST_PT2  = 24'h000008,
        ST_PMT2 = 24'h000010,
        ST_PMTT = 24'h000020,
        ST_PK1  = 24'h000040,
        ST_PK2  = 24'h000080,
        ST_PT3  = 24'h000100,
        ST_X1   = 24'h000200,
        ST_X2   = 24'h000400,
        ST_D1   = 24'h000800,
        ST_D2   = 24'h001000,
        ST_D3   = 24'h002000,
        ST_CHK  = 24'h004000,
        ST_DIV  = 24'h008000,
        ST_UPD  = 24'h010000,
        ST_PW0  = 24'h020000,
        ST_S0   = 24'h040000,
        ST_S1   = 24'h080000,
        ST_S2   = 24'h100000,
        ST_S3   = 24'h200000,
        ST_RND  = 24'h400000,
        ST_FIN  = 24'h800000
    } t_state;

    // which normalized value the current division produces
    typedef enum logic [1:0] {
        SEL_U = 2'd0,
        SEL_A = 2'd1,
        SEL_B = 2'd2
    } t_nsel;

    t_state             r_state, n_state;
    t_in_item           r_in, n_in;
    logic signed [16:0] r_span, n_span;
    t_nsel              r_sel, n_sel;
    logic [QW-1:0]      r_u, n_u, r_a, n_a, r_b, n_b, r_t, n_t;
    logic [QW-1:0]      r_t2, n_t2, r_mt2, n_mt2, r_mtt, n_mtt;
    logic [QW-1:0]      r_k1, n_k1, r_k2, n_k2, r_t3, n_t3, r_w0, n_w0;
    logic signed [33:0] r_x, n_x;
    logic signed [AccW-1:0] r_acc, n_acc;
    logic [31:0]        r_qmag, n_qmag;
    logic               r_qneg, n_qneg;
    logic [IterW-1:0]   r_iter, n_iter;
    logic               r_final, n_final;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    // shared multiplier
    logic signed [31:0]     mul_a, mul_b;
    logic signed [63:0]     mul_p, mul_adj;
    logic signed [33:0]     mul_q;
    logic signed [AccW-1:0] mq_ext, pr_ext;

    logic [QW-1:0]          mt, one_b;
    logic signed [31:0]     b_min_a;
    logic signed [16:0]     span_in, nn;
    logic signed [33:0]     d_s;
    logic [DivW-1:0]        mag_d, mag_n;
    logic signed [34:0]     num_s;
    logic                   flat;
    logic signed [33:0]     nt_w;
    logic [QW-1:0]          nt_c;
    logic signed [31:0]     diff;
    logic                   small_step;
    logic signed [AccW-1:0] rnd_sum;
    logic signed [19:0]     rnd;
    logic [15:0]            sat;
    logic [QW-1:0]          norm_val;

    logic                   div_start, div_done;
    logic [DivW-1:0]        div_num, div_den;
    logic [QuoBits-1:0]     div_quo;

    logic in_xfer, out_xfer;

    cbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;

    // datapath terms shared by several states
    always_comb begin
        mt      = QONE - r_t;
        one_b   = QONE - r_b;
        b_min_a = $signed({1'b0, r_b}) - $signed({1'b0, r_a});
        span_in = 17'(i_in.end_x) - 17'(i_in.start_x);

        case (r_sel)
            SEL_U:   nn = 17'(r_in.progress) - 17'(r_in.start_x);
            SEL_A:   nn = 17'(r_in.ctrl_a_x) - 17'(r_in.start_x);
            SEL_B:   nn = 17'(r_in.ctrl_b_x) - 17'(r_in.start_x);
            default: nn = '0;
        endcase

        // derivative and residual for the newton step
        d_s   = r_acc[33:0];
        mag_d = d_s[33] ? DivW'(-d_s) : DivW'(d_s);
        num_s = 35'(r_x) - $signed({4'b0, r_u});
        mag_n = num_s[34] ? DivW'(-num_s) : DivW'(num_s);
        flat  = (d_s > -34'(TinyQ30)) && (d_s < 34'(TinyQ30));

        // clamped newton update
        nt_w = r_qneg ? $signed({3'b0, r_t}) + $signed({2'b0, r_qmag})
                      : $signed({3'b0, r_t}) - $signed({2'b0, r_qmag});
        if (nt_w < 0) begin
            nt_c = '0;
        end else if (nt_w > $signed({3'b0, QONE})) begin
            nt_c = QONE;
        end else begin
            nt_c = nt_w[QW-1:0];
        end
        diff       = $signed({1'b0, nt_c}) - $signed({1'b0, r_t});
        small_step = (diff > -32'(TinyQ30)) && (diff < 32'(TinyQ30));

        // round to nearest, ties up, then saturate
        rnd_sum = r_acc + (AccW'(1) <<< 29);
        rnd     = rnd_sum[49:30];
        if (rnd > 20'sd32767) begin
            sat = 16'h7fff;
        end else if (rnd < -20'sd32768) begin
            sat = 16'h8000;
        end else begin
            sat = rnd[15:0];
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_PT2:  begin mul_a = $signed({1'b0, r_t});   mul_b = $signed({1'b0, r_t}); end
            ST_PMT2: begin mul_a = $signed({1'b0, mt});    mul_b = $signed({1'b0, mt}); end
            ST_PMTT: begin mul_a = $signed({1'b0, mt});    mul_b = $signed({1'b0, r_t}); end
            ST_PK1:  begin mul_a = $signed({1'b0, r_mt2}); mul_b = $signed({1'b0, r_t}); end
            ST_PK2:  begin mul_a = $signed({1'b0, r_mtt}); mul_b = $signed({1'b0, r_t}); end
            ST_PT3:  begin mul_a = $signed({1'b0, r_t2});  mul_b = $signed({1'b0, r_t}); end
            ST_X1:   begin mul_a = $signed({1'b0, r_k1});  mul_b = $signed({1'b0, r_a}); end
            ST_X2:   begin mul_a = $signed({1'b0, r_k2});  mul_b = $signed({1'b0, r_b}); end
            ST_D1:   begin mul_a = $signed({1'b0, r_mt2}); mul_b = $signed({1'b0, r_a}); end
            ST_D2:   begin mul_a = b_min_a;                mul_b = $signed({1'b0, r_mtt}); end
            ST_D3:   begin mul_a = $signed({1'b0, r_t2});  mul_b = $signed({1'b0, one_b}); end
            ST_PW0:  begin mul_a = $signed({1'b0, r_mt2}); mul_b = $signed({1'b0, mt}); end
            ST_S0:   begin mul_a = $signed({1'b0, r_w0});  mul_b = 32'(r_in.start_y); end
            ST_S1:   begin mul_a = $signed({1'b0, r_k1});  mul_b = 32'(r_in.ctrl_a_y); end
            ST_S2:   begin mul_a = $signed({1'b0, r_k2});  mul_b = 32'(r_in.ctrl_b_y); end
            ST_S3:   begin mul_a = $signed({1'b0, r_t3});  mul_b = 32'(r_in.end_y); end
            default: begin mul_a = '0;                     mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
        // q30 product truncated toward zero
        mul_adj = mul_p + (mul_p[63] ? 64'sd1073741823 : 64'sd0);
        mul_q   = mul_adj[63:30];
        mq_ext  = AccW'(mul_q);
        pr_ext  = $signed(mul_p[AccW-1:0]);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_span      = r_span;
        n_sel       = r_sel;
        n_u         = r_u;
        n_a         = r_a;
        n_b         = r_b;
        n_t         = r_t;
        n_t2        = r_t2;
        n_mt2       = r_mt2;
        n_mtt       = r_mtt;
        n_k1        = r_k1;
        n_k2        = r_k2;
        n_t3        = r_t3;
        n_w0        = r_w0;
        n_x         = r_x;
        n_acc       = r_acc;
        n_qmag      = r_qmag;
        n_qneg      = r_qneg;
        n_iter      = r_iter;
        n_final     = r_final;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_xfer;
        div_start   = 1'b0;
        div_num     = mag_n;
        div_den     = mag_d;
        norm_val    = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_in    = i_in;
                    n_span  = span_in;
                    n_sel   = SEL_U;
                    n_iter  = '0;
                    n_final = 1'b0;
                    if (span_in <= 0) begin
                        n_res.eased_y   = i_in.end_y;
                        n_res.hold_step = 1'b1;
                        n_state         = ST_FIN;
                    end else begin
                        n_state = ST_NSET;
                    end
                end
            end
            ST_NSET: begin
                div_num = DivW'(unsigned'(nn));
                div_den = DivW'(unsigned'(r_span));
                if (nn <= 0 || nn >= r_span) begin
                    norm_val = (nn <= 0) ? '0 : QONE;
                    case (r_sel)
                        SEL_U:   n_u = norm_val;
                        SEL_A:   n_a = norm_val;
                        default: n_b = norm_val;
                    endcase
                    if (r_sel == SEL_B) begin
                        n_t     = r_u;
                        n_state = ST_PT2;
                    end else begin
                        n_sel = t_nsel'(r_sel + 2'd1);
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_NDIV;
                end
            end
            ST_NDIV: begin
                if (div_done) begin
                    case (r_sel)
                        SEL_U:   n_u = div_quo;
                        SEL_A:   n_a = div_quo;
                        default: n_b = div_quo;
                    endcase
                    if (r_sel == SEL_B) begin
                        n_t     = r_u;
                        n_state = ST_PT2;
                    end else begin
                        n_sel   = t_nsel'(r_sel + 2'd1);
                        n_state = ST_NSET;
                    end
                end
            end
            // powers of t and 1-t
            ST_PT2:  begin n_t2  = mul_q[QW-1:0]; n_state = ST_PMT2; end
            ST_PMT2: begin n_mt2 = mul_q[QW-1:0]; n_state = ST_PMTT; end
            ST_PMTT: begin n_mtt = mul_q[QW-1:0]; n_state = ST_PK1;  end
            ST_PK1:  begin n_k1  = mul_q[QW-1:0]; n_state = ST_PK2;  end
            ST_PK2:  begin n_k2  = mul_q[QW-1:0]; n_state = ST_PT3;  end
            ST_PT3: begin
                n_t3    = mul_q[QW-1:0];
                n_state = r_final ? ST_PW0 : ST_X1;
            end
            // x(t)
            ST_X1: begin
                n_acc   = (mq_ext <<< 1) + mq_ext;
                n_state = ST_X2;
            end
            ST_X2: begin
                n_acc   = r_acc + (mq_ext <<< 1) + mq_ext + $signed({19'b0, r_t3});
                n_x     = n_acc[33:0];
                n_state = ST_D1;
            end
            // x'(t)
            ST_D1: begin
                n_acc   = (mq_ext <<< 1) + mq_ext;
                n_state = ST_D2;
            end
            ST_D2: begin
                n_acc   = r_acc + (mq_ext <<< 2) + (mq_ext <<< 1);
                n_state = ST_D3;
            end
            ST_D3: begin
                n_acc   = r_acc + (mq_ext <<< 1) + mq_ext;
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_qneg = num_s[34] ^ d_s[33];
                if (flat) begin
                    n_final = 1'b1;
                    n_state = ST_PT2;
                end else if ({1'b0, mag_n} >= {mag_d, 1'b0}) begin
                    // step of 2.0 or more: the update clamps either way
                    n_qmag  = 32'h8000_0000;
                    n_state = ST_UPD;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_qmag  = {1'b0, div_quo};
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_t     = nt_c;
                n_iter  = r_iter + 1'b1;
                n_state = ST_PT2;
                if (small_step || (r_iter == IterW'(NewtonSteps - 1))) begin
                    n_final = 1'b1;
                end
            end
            // y(t), full-precision products summed in q30
            ST_PW0: begin n_w0 = mul_q[QW-1:0]; n_state = ST_S0; end
            ST_S0: begin
                n_acc   = pr_ext;
                n_state = ST_S1;
            end
            ST_S1: begin
                n_acc   = r_acc + (pr_ext <<< 1) + pr_ext;
                n_state = ST_S2;
            end
            ST_S2: begin
                n_acc   = r_acc + (pr_ext <<< 1) + pr_ext;
                n_state = ST_S3;
            end
            ST_S3: begin
                n_acc   = r_acc + pr_ext;
                n_state = ST_RND;
            end
            ST_RND: begin
                n_res.eased_y   = sat;
                n_res.hold_step = 1'b0;
                n_state         = ST_FIN;
            end
            ST_FIN: begin
                // wait for a free output register
                if (!r_out_valid || out_xfer) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_span <= n_span;
        r_u    <= n_u;
        r_a    <= n_a;
        r_b    <= n_b;
        r_t    <= n_t;
        r_t2   <= n_t2;
        r_mt2  <= n_mt2;
        r_mtt  <= n_mtt;
        r_k1   <= n_k1;
        r_k2   <= n_k2;
        r_t3   <= n_t3;
        r_w0   <= n_w0;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_qmag <= n_qmag;
        r_qneg <= n_qneg;
        r_res  <= n_res;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= SEL_U;
            r_iter      <= '0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_iter      <= n_iter;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* hw/rtl/cbe_chk.sv */
module cbe_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input cbe_pkg::t_in_item  i_in,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cbe_pkg::t_out_item o_out
);
    import cbe_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    // one item at a time: busy right after a transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // a new result appears only as the block goes idle
    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result raised while busy");

    // no result in the cycle right after a transfer in
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");

endmodule

bind cubic_bezier_ease_eval cbe_chk u_cbe_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in        (i_in),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

/* verif/cbe_checker.sv */
`timescale 1ns / 1ps

module cbe_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cbe_pkg::t_in_item  i_in,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cbe_pkg::t_out_item i_out,
    output int                 o_errors,
    output int                 o_pending
);
    import cbe_pkg::*;

    localparam longint QOne = 64'sd1 << 30;

    t_out_item eased_q[$];

    function automatic longint qmul(longint p, longint q);
        return (p * q) >>> 30;
    endfunction

    function automatic longint smul(longint s, longint w);
        if (s < 0) return -(((-s) * w) >>> 30);
        return (s * w) >>> 30;
    endfunction

    function automatic longint norm_clamp(longint num, longint span);
        if (num <= 0) return 0;
        if (num >= span) return QOne;
        return (num <<< 30) / span;
    endfunction

    function automatic longint sdiv(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n <<< 30) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic t_out_item ease_point(t_in_item it);
        t_out_item r;
        longint x0, span, u, a, b, t, mt, t2, mt2, mtt, k1, k2, t3, w0, sum, y;
        longint x, d, nt, diff;
        x0   = it.start_x;
        span = longint'(it.end_x) - x0;
        if (span <= 0) begin
            r.eased_y  = it.end_y;
            r.hold_step = 1'b1;
            return r;
        end
        u = norm_clamp(longint'(it.progress) - x0, span);
        a = norm_clamp(longint'(it.ctrl_a_x) - x0, span);
        b = norm_clamp(longint'(it.ctrl_b_x) - x0, span);
        t = u;
        for (int i = 0; i < NewtonSteps; i++) begin
            mt  = QOne - t;
            t2  = qmul(t, t);
            mt2 = qmul(mt, mt);
            mtt = qmul(mt, t);
            k1  = qmul(mt2, t);
            k2  = qmul(mtt, t);
            t3  = qmul(t2, t);
            x = 3 * qmul(k1, a) + 3 * qmul(k2, b) + t3;
            d = 3 * qmul(mt2, a) + 6 * smul(b - a, mtt) + 3 * qmul(t2, QOne - b);
            if (d > -TinyQ30 && d < TinyQ30) break;
            nt = t - sdiv(x - u, d);
            if (nt < 0) nt = 0;
            if (nt > QOne) nt = QOne;
            diff = nt - t;
            t = nt;
            if (diff > -TinyQ30 && diff < TinyQ30) break;
        end
        mt  = QOne - t;
        t2  = qmul(t, t);
        mt2 = qmul(mt, mt);
        mtt = qmul(mt, t);
        k1  = qmul(mt2, t);
        k2  = qmul(mtt, t);
        t3  = qmul(t2, t);
        w0  = qmul(mt2, mt);
        sum = w0 * it.start_y + 3 * k1 * it.ctrl_a_y + 3 * k2 * it.ctrl_b_y
            + t3 * it.end_y;
        // round half up, arithmetic shift floors
        y = (sum + (64'sd1 << 29)) >>> 30;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        r.eased_y   = 16'(y);
        r.hold_step = 1'b0;
        return r;
    endfunction

    assign o_pending = eased_q.size();

    always @(posedge i_clk) begin
        t_out_item exp_item;
        int        err_n;
        err_n = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
            eased_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                eased_q.push_back(ease_point(i_in));
            if (i_out_valid && !i_out_stall) begin
                if (eased_q.size() == 0) begin
                    $display("%0t: unexpected result transfer %p", $time, i_out);
                    err_n++;
                end else begin
                    exp_item = eased_q.pop_front();
                    if (exp_item.eased_y !== i_out.eased_y) begin
                        $display("%0t: eased_y expected %0d actual %0d", $time,
                                 exp_item.eased_y, i_out.eased_y);
                        err_n++;
                    end
                    if (exp_item.hold_step !== i_out.hold_step) begin
                        $display("%0t: hold_step expected %0b actual %0b", $time,
                                 exp_item.hold_step, i_out.hold_step);
                        err_n++;
                    end
                end
            end
            o_errors <= o_errors + err_n;
        end
    end

endmodule

/* verif/tb_cubic_bezier_ease_eval.sv */
`timescale 1ns / 1ps

module tb_cubic_bezier_ease_eval;
    import cbe_pkg::*;

    localparam int RandomItems = 1880;
    localparam int IdleLimit   = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        errors;
    int        pending;
    bit        hold_off;
    int        idle_cycles;

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    cubic_bezier_ease_eval DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in       (in_item),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    cbe_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in       (in_item),
        .i_in_stall (in_stall),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out      (out_item),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // random value biased toward the interesting corners of q2.14
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 16384));
            3: return 16'($urandom_range(0, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // well-formed segment: x increasing, controls in span, progress mostly in span
    function automatic t_in_item pick_segment();
        t_in_item it;
        int x0, sp;
        x0 = $urandom_range(0, 40000) - 32768;
        sp = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8)
                                       : $urandom_range(1, 32767 - x0);
        it.start_x  = 16'(x0);
        it.end_x    = 16'(x0 + sp);
        it.ctrl_a_x = 16'(x0 + $urandom_range(0, sp));
        it.ctrl_b_x = 16'(x0 + $urandom_range(0, sp));
        it.progress = $urandom_range(0, 7) == 0 ? pick_word()
                                                : 16'(x0 + $urandom_range(0, sp));
        it.start_y  = pick_word();
        it.ctrl_a_y = pick_word();
        it.ctrl_b_y = pick_word();
        it.end_y    = pick_word();
        return it;
    endfunction

    // hands one item over and waits for its transfer
    task automatic send_item(t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off  <= 1'b0;
                out_stall <= 1'b0;
            end else begin
                mode = ($time / 50000) % 3;
                if (mode == 0) out_stall <= 1'b0;
                else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
                else out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // watchdog: no transfer on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("cubic_bezier_ease_eval regression: fail");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int burst;
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        hold_off <= 1'b0;
        idle_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: linear, ease, hold steps, out-of-span, extremes
        it = '{start_x: 16'sd0, start_y: 16'sd0, ctrl_a_x: 16'sd5461, ctrl_a_y: 16'sd5461,
               ctrl_b_x: 16'sd10923, ctrl_b_y: 16'sd10923, end_x: 16'sd16384,
               end_y: 16'sd16384, progress: 16'sd8192};
        send_item(it);
        it.progress = 16'sd0;      send_item(it);
        it.progress = 16'sd16384;  send_item(it);
        it.progress = -16'sd32768; send_item(it);
        it.progress = 16'sd32767;  send_item(it);
        it.ctrl_a_x = 16'sd4096; it.ctrl_a_y = 16'sd1638;
        it.ctrl_b_x = 16'sd4096; it.ctrl_b_y = 16'sd16384;
        it.progress = 16'sd6000;   send_item(it);
        // flat derivative: both controls at the left end, t stuck near zero
        it.ctrl_a_x = 16'sd0; it.ctrl_b_x = 16'sd0; it.progress = 16'sd1;
        send_item(it);
        // controls beyond the span on both sides
        it.ctrl_a_x = -16'sd32768; it.ctrl_b_x = 16'sd32767; it.progress = 16'sd9000;
        send_item(it);
        // extreme y values, saturating overshoot
        it = '{start_x: -16'sd32768, start_y: -16'sd32768, ctrl_a_x: 16'sd32767,
               ctrl_a_y: 16'sd32767, ctrl_b_x: -16'sd32768, ctrl_b_y: -16'sd32768,
               end_x: 16'sd32767, end_y: 16'sd32767, progress: 16'sd0};
        send_item(it);
        it.ctrl_a_y = -16'sd32768; it.ctrl_b_y = -16'sd32768; it.start_y = -16'sd32768;
        it.end_y = -16'sd32768;    send_item(it);
        it.ctrl_a_y = 16'sd32767; it.ctrl_b_y = 16'sd32767; it.start_y = 16'sd32767;
        it.end_y = 16'sd32767; it.progress = 16'sd100; send_item(it);
        // hold steps: zero span and negative span, then a span of one
        it.end_x = it.start_x;     send_item(it);
        it.start_x = 16'sd32767; it.end_x = -16'sd32768; it.end_y = -16'sd5;
        send_item(it);
        it.start_x = 16'sd1; it.end_x = 16'sd2; send_item(it);
        drop_valid();

        // long receiver hold-off while the sender keeps offering
        hold_off <= 1'b1;
        for (int i = 0; i < 6; i++) send_item(pick_segment());
        drop_valid();
        // drain before continuing
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < RandomItems; ) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++, n++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        it = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
                        send_item(it);
                    end
                    1: begin
                        it = pick_segment();
                        it.end_x = it.start_x - 16'($urandom_range(0, 3));
                        send_item(it);
                    end
                    default: send_item(pick_segment());
                endcase
            end
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if (n > 900 && n < 914)
                while (pending != 0) @(posedge i_clk);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("cubic_bezier_ease_eval regression: pass");
        else
            $display("cubic_bezier_ease_eval regression: fail");
        $finish;
    end

endmodule
